/* hw/rtl/luf_pkg.sv */
// Shared types and constants of the Luffa-512 fixed-length hash block.
package luf_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_HEAD = 2'd1,
    CMD_TAIL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_INJECT = 2'd1,
    ST_STEP   = 2'd2,
    ST_OUT    = 2'd3
  } back_state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] data_word;
    logic [4:0]  midstate_index;
    logic [7:0]  dest_tag;
  } in_t;

  typedef struct packed {
    logic [63:0] hash_word;
    logic        hash_last;
    logic [7:0]  dest_out;
  } out_t;

  typedef logic [7:0][31:0] chain_t;
  typedef chain_t [4:0] chains_t;
  typedef logic [19:0][63:0] mids_t;

  typedef struct packed {
    logic             head;
    logic [7:0][63:0] msg;
    logic [7:0]       dest;
  } job_t;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;

  localparam logic [3:0] CRUMB [16] = '{
    4'd13, 4'd14, 4'd0, 4'd1, 4'd5, 4'd10, 4'd7, 4'd6,
    4'd11, 4'd3, 4'd9, 4'd12, 4'd15, 4'd8, 4'd2, 4'd4
  };

  localparam logic [31:0] IV [5][8] = '{
    '{32'h6d251e69, 32'h44b051e0, 32'h4eaa6fb4, 32'hdbf78465,
      32'h6e292011, 32'h90152df4, 32'hee058139, 32'hdef610bb},
    '{32'hc3b44b95, 32'hd9d2f256, 32'h70eee9a0, 32'hde099fa3,
      32'h5d9b0557, 32'h8fc944b3, 32'hcf1ccf0e, 32'h746cd581},
    '{32'hf7efc89d, 32'h5dba5781, 32'h04016ce5, 32'had659c05,
      32'h0306194f, 32'h666d1836, 32'h24aa230a, 32'h8b264ae7},
    '{32'h858075d5, 32'h36d79cce, 32'he571f7d7, 32'h204b1f67,
      32'h35870c6a, 32'h57e9e923, 32'h14bcb808, 32'h7cde72ce},
    '{32'h6c68e9be, 32'h5ec41e22, 32'hc825b7c7, 32'haffb4363,
      32'hf5df3999, 32'h0fc688f1, 32'hb07224cc, 32'h03e86cea}
  };

  localparam logic [31:0] STEP_C [8][5][2] = '{
    '{'{32'h303994a6, 32'he0337818}, '{32'hb6de10ed, 32'h01685f3d},
      '{32'hfc20d9d2, 32'he25e72c1}, '{32'hb213afa5, 32'he028c9bf},
      '{32'hf0d2e9e3, 32'h5090d577}},
    '{'{32'hc0e65299, 32'h441ba90d}, '{32'h70f47aae, 32'h05a17cf4},
      '{32'h34552e25, 32'he623bb72}, '{32'hc84ebe95, 32'h44756f91},
      '{32'hac11d7fa, 32'h2d1925ab}},
    '{'{32'h6cc33a12, 32'h7f34d442}, '{32'h0707a3d4, 32'hbd09caca},
      '{32'h7ad8818f, 32'h5c58a4a4}, '{32'h4e608a22, 32'h7e8fce32},
      '{32'h1bcb66f2, 32'hb46496ac}},
    '{'{32'hdc56983e, 32'h9389217f}, '{32'h1c1e8f51, 32'hf4272b28},
      '{32'h8438764a, 32'h1e38e2e7}, '{32'h56d858fe, 32'h956548be},
      '{32'h6f2d9bc9, 32'hd1925ab0}},
    '{'{32'h1e00108f, 32'he5a8bce6}, '{32'h707a3d45, 32'h144ae5cc},
      '{32'hbb6de032, 32'h78e38b9d}, '{32'h343b138f, 32'hfe191be2},
      '{32'h78602649, 32'h29131ab6}},
    '{'{32'h7800423d, 32'h5274baf4}, '{32'haeb28562, 32'hfaa7ae2b},
      '{32'hedb780c8, 32'h27586719}, '{32'hd0ec4e3d, 32'h3cb226e5},
      '{32'h8edae952, 32'h0fc053c3}},
    '{'{32'h8f5b7882, 32'h26889ba7}, '{32'hbaca1589, 32'h2e48f1c1},
      '{32'hd9847356, 32'h36eda57f}, '{32'h2ceb4882, 32'h5944a28e},
      '{32'h3b6ba548, 32'h3f014f0c}},
    '{'{32'h96e1db12, 32'h9a226e9d}, '{32'h40a46f3e, 32'hb923c704},
      '{32'ha2c78434, 32'h703aace7}, '{32'hb3ad2208, 32'ha1c4c355},
      '{32'hedae9520, 32'hfc053c31}}
  };

endpackage

/* hw/rtl/luf_front.sv */
// Front end: accepts items, keeps the midstate and collects message words into jobs.
module luf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  luf_pkg::in_t   in_data_i,
  input  logic           busy_i,
  input  logic           q_full_i,
  output logic           push_o,
  output luf_pkg::job_t  job_o,
  output luf_pkg::mids_t mids_o
);

  logic [63:0]      mid_q [20];
  logic [7:0][63:0] msg_q;
  logic [2:0]       cnt_q, cnt_d;
  logic             mode_q, mode_d;
  logic [7:0]       dest_q, dest_d;
  logic             is_word, is_load, mode, complete, accept;
  logic [2:0]       idx;
  logic [7:0][63:0] msg_new;

  always_comb begin
    is_load  = (in_data_i.cmd == luf_pkg::CMD_LOAD);
    is_word  = (in_data_i.cmd == luf_pkg::CMD_HEAD) || (in_data_i.cmd == luf_pkg::CMD_TAIL);
    mode     = (in_data_i.cmd == luf_pkg::CMD_HEAD);
    idx      = (mode != mode_q) ? 3'd0 : cnt_q;
    complete = mode ? (idx == 3'd1) : (idx == 3'd7);
    dest_d   = (idx == 3'd0) ? in_data_i.dest_tag : dest_q;
    mode_d   = mode;
    cnt_d    = complete ? 3'd0 : idx + 3'd1;
    msg_new      = msg_q;
    msg_new[idx] = in_data_i.data_word;
    in_stall_o = (is_word && complete && q_full_i) || (is_load && busy_i);
    accept     = in_valid_i && !in_stall_o;
    push_o     = accept && is_word && complete;
    job_o.head = mode;
    job_o.msg  = msg_new;
    job_o.dest = dest_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= 1'b0;
      dest_q <= '0;
    end else if (accept && is_word) begin
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      dest_q <= dest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_word) begin
      msg_q <= msg_new;
    end
    if (accept && is_load && (in_data_i.midstate_index < 5'd20)) begin
      mid_q[in_data_i.midstate_index] <= in_data_i.data_word;
    end
  end

  always_comb begin
    for (int j = 0; j < 20; j++) begin
      mids_o[j] = mid_q[j];
    end
  end

endmodule

/* hw/rtl/luf_queue.sv */
// Two-entry job queue between the front end and the round engine.
module luf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  luf_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output luf_pkg::job_t job_o
);

  luf_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

/* hw/rtl/luf_back.sv */
// Round engine: message injection, eight permutation steps per round and digest output.
module luf_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  luf_pkg::job_t  job_i,
  output logic           pop_o,
  input  luf_pkg::mids_t mids_i,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output luf_pkg::out_t  out_data_o
);

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic luf_pkg::chain_t t2(luf_pkg::chain_t a);
    luf_pkg::chain_t t;
    t[0] = a[7];
    t[1] = a[7] ^ a[0];
    t[2] = a[1];
    t[3] = a[7] ^ a[2];
    t[4] = a[7] ^ a[3];
    t[5] = a[4];
    t[6] = a[5];
    t[7] = a[6];
    return t;
  endfunction

  function automatic luf_pkg::chain_t fold(luf_pkg::chains_t ch);
    luf_pkg::chain_t s;
    s = '0;
    for (int c = 0; c < 5; c++) begin
      s = s ^ ch[c];
    end
    return s;
  endfunction

  function automatic luf_pkg::chains_t inject(luf_pkg::chains_t ch, luf_pkg::chain_t m);
    luf_pkg::chain_t  s, mm;
    luf_pkg::chains_t a, b, r;
    s = t2(fold(ch));
    for (int c = 0; c < 5; c++) begin
      ch[c] = ch[c] ^ s;
    end
    for (int c = 0; c < 5; c++) begin
      a[c] = t2(ch[c]) ^ ch[(c == 4) ? 0 : c + 1];
    end
    for (int c = 0; c < 5; c++) begin
      b[c] = t2(a[c]) ^ a[(c == 0) ? 4 : c - 1];
    end
    mm = m;
    for (int c = 0; c < 5; c++) begin
      r[c] = b[c] ^ mm;
      mm = t2(mm);
      for (int k = 4; k < 8; k++) begin
        r[c][k] = rol(r[c][k], c);
      end
    end
    return r;
  endfunction

  function automatic luf_pkg::chain_t step(luf_pkg::chain_t x, int c, logic [2:0] st);
    luf_pkg::chain_t r;
    logic [3:0]  ia, ib, ca, cb;
    logic [31:0] a, b;
    for (int i = 0; i < 32; i++) begin
      ia = {x[3][i], x[2][i], x[1][i], x[0][i]};
      ib = {x[4][i], x[7][i], x[6][i], x[5][i]};
      ca = luf_pkg::CRUMB[ia];
      cb = luf_pkg::CRUMB[ib];
      r[3][i] = ca[3];
      r[2][i] = ca[2];
      r[1][i] = ca[1];
      r[0][i] = ca[0];
      r[4][i] = cb[3];
      r[7][i] = cb[2];
      r[6][i] = cb[1];
      r[5][i] = cb[0];
    end
    for (int i = 0; i < 4; i++) begin
      a = r[i];
      b = r[i + 4];
      b = b ^ a;
      a = rol(a, 2) ^ b;
      b = rol(b, 14) ^ a;
      a = rol(a, 10) ^ b;
      b = rol(b, 1);
      r[i]     = a;
      r[i + 4] = b;
    end
    r[0] = r[0] ^ luf_pkg::STEP_C[st][c][0];
    r[4] = r[4] ^ luf_pkg::STEP_C[st][c][1];
    return r;
  endfunction

  function automatic logic [255:0] msb_first(luf_pkg::chain_t z);
    logic [255:0] v;
    for (int k = 0; k < 8; k++) begin
      v[255 - 32 * k -: 32] = z[k];
    end
    return v;
  endfunction

  luf_pkg::back_state_e state_q, state_d;
  luf_pkg::chains_t     chains_q, chains_inj, chains_stp, chains_ld;
  luf_pkg::chain_t      blk, z_new;
  logic                 head_q;
  logic [7:0][63:0]     msg_q;
  logic [7:0]           dest_q;
  logic [2:0]           round_q, step_q, wcnt_q, last_round;
  logic [255:0]         z_q;
  logic [511:0]         dig_q;
  logic                 out_fire, step_end;

  assign last_round = head_q ? 3'd2 : 3'd4;
  assign out_fire   = out_valid_o && !out_stall_i;
  assign step_end   = (state_q == luf_pkg::ST_STEP) && (step_q == 3'd7);

  always_comb begin
    blk = '0;
    if (head_q) begin
      if (round_q == 3'd0) begin
        blk[0] = msg_q[0][63:32];
        blk[1] = msg_q[0][31:0];
        blk[2] = msg_q[1][63:32];
        blk[3] = msg_q[1][31:0];
        blk[4] = luf_pkg::PAD_WORD;
      end
    end else if (round_q == 3'd0 || round_q == 3'd1) begin
      for (int j = 0; j < 4; j++) begin
        blk[2 * j]     = msg_q[{round_q[0], 2'(j)}][63:32];
        blk[2 * j + 1] = msg_q[{round_q[0], 2'(j)}][31:0];
      end
    end else if (round_q == 3'd2) begin
      blk[0] = luf_pkg::PAD_WORD;
    end
  end

  always_comb begin
    chains_inj = inject(chains_q, blk);
    for (int c = 0; c < 5; c++) begin
      chains_stp[c] = step(chains_q[c], c, step_q);
    end
    z_new = fold(chains_stp);
    for (int c = 0; c < 5; c++) begin
      for (int k = 0; k < 8; k++) begin
        if (job_i.head) begin
          chains_ld[c][k] = k[0] ? mids_i[(c * 8 + k) / 2][31:0]
                                 : mids_i[(c * 8 + k) / 2][63:32];
        end else begin
          chains_ld[c][k] = luf_pkg::IV[c][k];
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      luf_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          state_d = luf_pkg::ST_INJECT;
        end
      end
      luf_pkg::ST_INJECT: state_d = luf_pkg::ST_STEP;
      luf_pkg::ST_STEP: begin
        if (step_q == 3'd7) begin
          state_d = (round_q == last_round) ? luf_pkg::ST_OUT : luf_pkg::ST_INJECT;
        end
      end
      luf_pkg::ST_OUT: begin
        if (out_fire && wcnt_q == 3'd7) begin
          state_d = luf_pkg::ST_IDLE;
        end
      end
      default: state_d = luf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    busy_o      = 1'b1;
    case (state_q)
      luf_pkg::ST_IDLE: begin
        pop_o  = q_valid_i;
        busy_o = q_valid_i;
      end
      luf_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign out_data_o.hash_word = dig_q[511:448];
  assign out_data_o.hash_last = (wcnt_q == 3'd7);
  assign out_data_o.dest_out  = dest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= luf_pkg::ST_IDLE;
      round_q <= '0;
      step_q  <= '0;
      wcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        round_q <= '0;
      end else if (step_end && round_q != last_round) begin
        round_q <= round_q + 3'd1;
      end
      if (state_q == luf_pkg::ST_INJECT) begin
        step_q <= '0;
      end else if (state_q == luf_pkg::ST_STEP) begin
        step_q <= step_q + 3'd1;
      end
      if (state_q != luf_pkg::ST_OUT) begin
        wcnt_q <= '0;
      end else if (out_fire) begin
        wcnt_q <= wcnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      head_q   <= job_i.head;
      msg_q    <= job_i.msg;
      dest_q   <= job_i.dest;
      chains_q <= chains_ld;
    end else if (state_q == luf_pkg::ST_INJECT) begin
      chains_q <= chains_inj;
    end else if (state_q == luf_pkg::ST_STEP) begin
      chains_q <= chains_stp;
    end
    if (step_end && round_q == last_round - 3'd1) begin
      z_q <= msb_first(z_new);
    end
    if (step_end && round_q == last_round) begin
      dig_q <= {z_q, msb_first(z_new)};
    end else if (out_fire) begin
      dig_q <= {dig_q[447:0], 64'd0};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |-> q_valid_i)
    else $error("job taken from an empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) round_q <= 3'd4)
    else $error("round count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_data_o.hash_last) |=> (state_q == luf_pkg::ST_IDLE))
    else $error("engine not idle after last digest transfer");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_end |=> (state_q == luf_pkg::ST_INJECT || state_q == luf_pkg::ST_OUT))
    else $error("round did not close properly");

endmodule

/* hw/rtl/luffa512_fixed_length_hash.sv */
// Luffa-512 hash of fixed-length messages with midstate resume, top level.
// Tail mode runs 5 rounds in the shared engine, head mode 3.
// The digest goes out as 8 transfers of one 64-bit word after the last round of a message.
// Messages queue up meanwhile; the engine takes the next one only after the last transfer.
// Asynchronous active-low reset clears control state; the midstate is undefined until loaded.
module luffa512_fixed_length_hash (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  luf_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output luf_pkg::out_t out_data_o
);

  logic           push, pop, q_full, q_valid, back_busy;
  luf_pkg::job_t  job_in, job_out;
  luf_pkg::mids_t mids;

  luf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .busy_i     (back_busy || q_valid),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in),
    .mids_o     (mids)
  );

  luf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (job_out)
  );

  luf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .mids_i      (mids),
    .busy_o      (back_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sim/luffa512_fixed_length_hash_tb.sv */
// Testbench of the Luffa-512 fixed-length hash block with a digest scoreboard.
`timescale 1ns / 100ps

module luffa512_fixed_length_hash_tb;

  class digest_board;
    logic [63:0] mids [20];
    logic [31:0] cv [5][8];
    logic [63:0] msg [8];
    int unsigned nwords;
    bit head_mode;
    logic [7:0] tag;
    luf_pkg::out_t pending [$];
    int unsigned errors;
    int unsigned digests;
    int unsigned loads;

    function new();
      foreach (mids[i]) mids[i] = '0;
      nwords = 0;
      head_mode = 0;
      tag = '0;
      errors = 0;
      digests = 0;
      loads = 0;
    endfunction

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
      n = n % 32;
      if (n == 0) return v;
      return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void dbl(ref logic [31:0] a [8]);
      logic [31:0] t [8];
      t[0] = a[7];
      t[1] = a[7] ^ a[0];
      t[2] = a[1];
      t[3] = a[7] ^ a[2];
      t[4] = a[7] ^ a[3];
      t[5] = a[4];
      t[6] = a[5];
      t[7] = a[6];
      a = t;
    endfunction

    function automatic void inject(logic [31:0] blk [8]);
      logic [31:0] s [8];
      logic [31:0] a [5][8];
      logic [31:0] b [5][8];
      logic [31:0] tw [8];
      logic [31:0] mm [8];
      for (int k = 0; k < 8; k++) s[k] = cv[0][k] ^ cv[1][k] ^ cv[2][k] ^ cv[3][k] ^ cv[4][k];
      dbl(s);
      for (int c = 0; c < 5; c++) for (int k = 0; k < 8; k++) cv[c][k] ^= s[k];
      for (int c = 0; c < 5; c++) begin
        tw = cv[c];
        dbl(tw);
        for (int k = 0; k < 8; k++) a[c][k] = tw[k] ^ cv[(c + 1) % 5][k];
      end
      for (int c = 0; c < 5; c++) begin
        tw = a[c];
        dbl(tw);
        for (int k = 0; k < 8; k++) b[c][k] = tw[k] ^ a[(c + 4) % 5][k];
      end
      mm = blk;
      for (int c = 0; c < 5; c++) begin
        for (int k = 0; k < 8; k++) cv[c][k] = b[c][k] ^ mm[k];
        dbl(mm);
      end
    endfunction

    function automatic void permute();
      logic [31:0] x [8];
      logic [31:0] r [8];
      logic [3:0] ia, ib, ca, cb;
      logic [31:0] p, q;
      for (int c = 0; c < 5; c++) for (int k = 4; k < 8; k++) cv[c][k] = rotl(cv[c][k], c);
      for (int st = 0; st < 8; st++) begin
        for (int c = 0; c < 5; c++) begin
          x = cv[c];
          foreach (r[k]) r[k] = '0;
          for (int i = 0; i < 32; i++) begin
            ia = {x[3][i], x[2][i], x[1][i], x[0][i]};
            ib = {x[4][i], x[7][i], x[6][i], x[5][i]};
            ca = luf_pkg::CRUMB[ia];
            cb = luf_pkg::CRUMB[ib];
            {r[3][i], r[2][i], r[1][i], r[0][i]} = ca;
            {r[4][i], r[7][i], r[6][i], r[5][i]} = cb;
          end
          for (int i = 0; i < 4; i++) begin
            p = r[i];
            q = r[i + 4];
            q ^= p;
            p = rotl(p, 2) ^ q;
            q = rotl(q, 14) ^ p;
            p = rotl(p, 10) ^ q;
            q = rotl(q, 1);
            r[i] = p;
            r[i + 4] = q;
          end
          r[0] ^= luf_pkg::STEP_C[st][c][0];
          r[4] ^= luf_pkg::STEP_C[st][c][1];
          cv[c] = r;
        end
      end
    endfunction

    function automatic void round_of(logic [31:0] blk [8]);
      inject(blk);
      permute();
    endfunction

    function automatic void note_input(luf_pkg::in_t it);
      logic [31:0] blk [8];
      logic [31:0] z [16];
      bit mode;
      int unsigned need;
      luf_pkg::out_t o;
      if (it.cmd == luf_pkg::CMD_LOAD) begin
        if (it.midstate_index < 20) mids[it.midstate_index] = it.data_word;
        loads++;
        return;
      end
      if (it.cmd == luf_pkg::CMD_NONE) return;
      mode = (it.cmd == luf_pkg::CMD_HEAD);
      if (mode != head_mode) begin
        head_mode = mode;
        nwords = 0;
      end
      if (nwords == 0) tag = it.dest_tag;
      msg[nwords % 8] = it.data_word;
      nwords = (nwords + 1) % 16;
      need = mode ? 2 : 8;
      if (nwords < need) return;
      nwords = 0;
      if (mode) begin
        for (int c = 0; c < 5; c++) for (int k = 0; k < 8; k += 2)
          {cv[c][k], cv[c][k + 1]} = mids[(c * 8 + k) / 2];
        {blk[0], blk[1]} = msg[0];
        {blk[2], blk[3]} = msg[1];
        blk[4] = luf_pkg::PAD_WORD;
        blk[5] = '0;
        blk[6] = '0;
        blk[7] = '0;
        round_of(blk);
      end else begin
        for (int c = 0; c < 5; c++) for (int k = 0; k < 8; k++) cv[c][k] = luf_pkg::IV[c][k];
        for (int k = 0; k < 4; k++) {blk[2 * k], blk[2 * k + 1]} = msg[k];
        round_of(blk);
        for (int k = 0; k < 4; k++) {blk[2 * k], blk[2 * k + 1]} = msg[4 + k];
        round_of(blk);
        foreach (blk[k]) blk[k] = '0;
        blk[0] = luf_pkg::PAD_WORD;
        round_of(blk);
      end
      for (int h = 0; h < 2; h++) begin
        foreach (blk[k]) blk[k] = '0;
        round_of(blk);
        for (int k = 0; k < 8; k++)
          z[h * 8 + k] = cv[0][k] ^ cv[1][k] ^ cv[2][k] ^ cv[3][k] ^ cv[4][k];
      end
      for (int k = 0; k < 8; k++) begin
        o.hash_word = {z[2 * k], z[2 * k + 1]};
        o.hash_last = (k == 7);
        o.dest_out = tag;
        pending.push_back(o);
      end
      digests++;
    endfunction

    function automatic void check_result(luf_pkg::out_t got);
      luf_pkg::out_t exp_o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected digest transfer %h", $time, got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.hash_word !== exp_o.hash_word) begin
        $display("%0t: hash_word expected %h actual %h", $time, exp_o.hash_word,
                 got.hash_word);
        errors++;
      end
      if (got.hash_last !== exp_o.hash_last) begin
        $display("%0t: hash_last expected %b actual %b", $time, exp_o.hash_last,
                 got.hash_last);
        errors++;
      end
      if (got.dest_out !== exp_o.dest_out) begin
        $display("%0t: dest_out expected %h actual %h", $time, exp_o.dest_out,
                 got.dest_out);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  luf_pkg::in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  luf_pkg::out_t out_data_o;

  digest_board board;
  bit calm;
  int hold_cycles;
  int unsigned sent;

  luffa512_fixed_length_hash dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    #2000000;
    $display("luffa512_fixed_length_hash_tb failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // Receiver: random stall bursts, a long hold-off when requested, none when calm.
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send(logic [1:0] cmd, logic [63:0] w, logic [4:0] idx, logic [7:0] tg);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= {cmd, w, idx, tg};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [63:0] rnd64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic load_midstate();
    for (int i = 0; i < 20; i++) send(luf_pkg::CMD_LOAD, rnd64(), 5'(i), 8'($urandom));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    calm = 0;
    hold_cycles = 0;
    sent = 0;
    board = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: extreme tail messages, full midstate, head chunks, mode change, ignored items.
    for (int i = 0; i < 8; i++) send(luf_pkg::CMD_TAIL, '0, '0, 8'hff);
    for (int i = 0; i < 8; i++) send(luf_pkg::CMD_TAIL, '1, 5'h1f, 8'h00);
    for (int i = 0; i < 20; i++) send(luf_pkg::CMD_LOAD, (i % 2) ? '1 : '0, 5'(i), 8'h5a);
    send(luf_pkg::CMD_LOAD, '1, 5'd20, 8'h00);
    send(luf_pkg::CMD_LOAD, '1, 5'd31, 8'h00);
    send(luf_pkg::CMD_NONE, '1, 5'd3, 8'hff);
    send(luf_pkg::CMD_HEAD, '1, 5'd0, 8'h80);
    send(luf_pkg::CMD_HEAD, '0, 5'd0, 8'h01);
    send(luf_pkg::CMD_TAIL, 64'h0123456789abcdef, '0, 8'h11);
    send(luf_pkg::CMD_TAIL, 64'hfedcba9876543210, '0, 8'h22);
    send(luf_pkg::CMD_HEAD, 64'h8000000000000001, '0, 8'h33);
    send(luf_pkg::CMD_HEAD, 64'h7ffffffffffffffe, '0, 8'h44);
    drain();

    // The sender pauses until all digests are out, then the receiver holds off long.
    hold_cycles = 400;
    for (int m = 0; m < 3; m++)
      for (int i = 0; i < 8; i++)
        send(luf_pkg::CMD_TAIL, rnd64(), 5'($urandom), 8'($urandom));
    drain();

    // Random phase: mostly well-formed messages, some broken ones and noise.
    load_midstate();
    while (sent < 260) begin
      if (sent > 215) calm = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: for (int i = 0; i < 8; i++)
          send(luf_pkg::CMD_TAIL, rnd64(), 5'($urandom), 8'($urandom));
        4, 5, 6: for (int i = 0; i < 2; i++)
          send(luf_pkg::CMD_HEAD, rnd64(), 5'($urandom), 8'($urandom));
        7: send($urandom_range(0, 1) ? luf_pkg::CMD_HEAD : luf_pkg::CMD_TAIL, rnd64(),
                5'($urandom), 8'($urandom));
        8: send(luf_pkg::CMD_LOAD, rnd64(), 5'($urandom_range(0, 31)), 8'($urandom));
        default: send(luf_pkg::CMD_NONE, rnd64(), 5'($urandom), 8'($urandom));
      endcase
    end
    drain();
    repeat (100) @(negedge clk_i);

    $display("Sent %0d transfers, %0d midstate loads; checked %0d digests.", sent,
             board.loads, board.digests);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("luffa512_fixed_length_hash_tb passed");
    else
      $display("luffa512_fixed_length_hash_tb failed");
    $finish;
  end
endmodule
